// ===== sv/lzhc_pkg.sv =====
package lzhc_pkg;

	// table geometry; HASH_ENTRIES is a power of two
	localparam int HASH_ENTRIES = 32768;
	localparam int WINDOW_SIZE  = 32768;
	localparam int HASH_BITS    = $clog2(HASH_ENTRIES);
	localparam int HASH_SHIFT   = 5;
	localparam int POS_BITS     = 16;
	localparam int BYTE_BITS    = 8;
	localparam int OP_BITS      = 2;
	localparam int INDEX_BITS   = 15;

	localparam logic [HASH_BITS-1:0] LAST_ENTRY = HASH_BITS'(HASH_ENTRIES - 1);
	localparam logic [POS_BITS-1:0]  WINDOW     = POS_BITS'(WINDOW_SIZE);

	// operation codes
	localparam logic [OP_BITS-1:0] OP_INSERT = 2'd0;
	localparam logic [OP_BITS-1:0] OP_UPDATE = 2'd1;
	localparam logic [OP_BITS-1:0] OP_SLIDE  = 2'd2;

	typedef enum logic [2:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_INS,
		ST_SLIDE,
		ST_SLIDE_END,
		ST_HOLD
	} state_t;

	// one port pair of a table
	typedef struct packed {
		logic                 rd_en;
		logic [HASH_BITS-1:0] rd_addr;
		logic                 wr_en;
		logic [HASH_BITS-1:0] wr_addr;
		logic [POS_BITS-1:0]  wr_data;
	} ram_ctl_t;

	// finished result offered to the output register
	typedef struct packed {
		logic                  valid;
		logic [POS_BITS-1:0]   match;
		logic [INDEX_BITS-1:0] hash;
	} result_t;

	// rolling hash: shift in the new byte and keep the table index bits
	function automatic logic [HASH_BITS-1:0] hash_next(logic [HASH_BITS-1:0] h,
		logic [BYTE_BITS-1:0] b);
		logic [HASH_BITS+HASH_SHIFT-1:0] wide;
		wide = {h, HASH_SHIFT'(0)} ^ (HASH_BITS+HASH_SHIFT)'(b);
		return wide[HASH_BITS-1:0];
	endfunction

	// slide one table entry down by the window
	function automatic logic [POS_BITS-1:0] slide_entry(logic [POS_BITS-1:0] v);
		logic [POS_BITS-1:0] r;
		r = (v >= WINDOW) ? POS_BITS'(v - WINDOW) : '0;
		return r;
	endfunction

	// report the low index bits of the hash
	function automatic logic [INDEX_BITS-1:0] hash_report(logic [HASH_BITS-1:0] h);
		logic [31:0] w;
		w = 32'(h);
		return w[INDEX_BITS-1:0];
	endfunction

endpackage

// ===== sv/lzhc_ram.sv =====
module lzhc_ram #(
	parameter int ADDR_BITS = 15,
	parameter int DATA_BITS = 16
) (
	input  logic                 clk,
	input  logic                 rd_en,
	input  logic [ADDR_BITS-1:0] rd_addr,
	output logic [DATA_BITS-1:0] rd_data,
	input  logic                 wr_en,
	input  logic [ADDR_BITS-1:0] wr_addr,
	input  logic [DATA_BITS-1:0] wr_data
);

	logic [DATA_BITS-1:0] mem [2**ADDR_BITS];
	logic [DATA_BITS-1:0] rd_data_q;

	// write port
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
	end

	// registered read port
	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_data_q <= mem[rd_addr];
		end
	end

	assign rd_data = rd_data_q;

endmodule

// ===== sv/lzhc_seq.sv =====
module lzhc_seq (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            in_valid,
	output logic                            in_stall,
	input  logic [lzhc_pkg::OP_BITS-1:0]    operation,
	input  logic [lzhc_pkg::BYTE_BITS-1:0]  next_byte,
	input  logic [lzhc_pkg::POS_BITS-1:0]   position,
	output lzhc_pkg::ram_ctl_t              head_ctl,
	output lzhc_pkg::ram_ctl_t              link_ctl,
	input  logic [lzhc_pkg::POS_BITS-1:0]   head_rdata,
	input  logic [lzhc_pkg::POS_BITS-1:0]   link_rdata,
	output lzhc_pkg::result_t               res,
	input  logic                            res_ready
);

	lzhc_pkg::state_t state_q, state_d;

	logic [lzhc_pkg::HASH_BITS-1:0] cnt_q;
	logic [lzhc_pkg::HASH_BITS-1:0] wa_q;
	logic                           sw_wr_q;
	logic [lzhc_pkg::HASH_BITS-1:0] hash_q;
	logic [lzhc_pkg::POS_BITS-1:0]  pos_q;
	logic [lzhc_pkg::POS_BITS-1:0]  match_q;

	logic                           accept;
	logic [lzhc_pkg::HASH_BITS-1:0] hash_new;

	assign accept   = in_valid && !in_stall;
	assign hash_new = lzhc_pkg::hash_next(hash_q, next_byte);

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			lzhc_pkg::ST_CLEAR: begin
				if (cnt_q == lzhc_pkg::LAST_ENTRY) state_d = lzhc_pkg::ST_IDLE;
			end
			lzhc_pkg::ST_IDLE: begin
				if (accept) begin
					if (operation == lzhc_pkg::OP_INSERT) begin
						state_d = lzhc_pkg::ST_INS;
					end else if (operation == lzhc_pkg::OP_SLIDE) begin
						state_d = lzhc_pkg::ST_SLIDE;
					end else if (!res_ready) begin
						state_d = lzhc_pkg::ST_HOLD;
					end
				end
			end
			lzhc_pkg::ST_INS, lzhc_pkg::ST_SLIDE_END, lzhc_pkg::ST_HOLD: begin
				state_d = res_ready ? lzhc_pkg::ST_IDLE : lzhc_pkg::ST_HOLD;
			end
			lzhc_pkg::ST_SLIDE: begin
				if (cnt_q == lzhc_pkg::LAST_ENTRY) state_d = lzhc_pkg::ST_SLIDE_END;
			end
			default: state_d = lzhc_pkg::ST_IDLE;
		endcase
	end

	// table ports, handshake and result
	always_comb begin
		in_stall  = 1'b1;
		head_ctl  = '0;
		link_ctl  = '0;
		res       = '0;
		res.hash  = lzhc_pkg::hash_report(hash_q);
		case (state_q)
			lzhc_pkg::ST_CLEAR: begin
				head_ctl.wr_en   = 1'b1;
				head_ctl.wr_addr = cnt_q;
				link_ctl.wr_en   = 1'b1;
				link_ctl.wr_addr = cnt_q;
			end
			lzhc_pkg::ST_IDLE: begin
				in_stall = 1'b0;
				if (in_valid) begin
					case (operation)
						lzhc_pkg::OP_INSERT: begin
							head_ctl.rd_en   = 1'b1;
							head_ctl.rd_addr = hash_new;
						end
						lzhc_pkg::OP_UPDATE: begin
							res.valid = 1'b1;
							res.hash  = lzhc_pkg::hash_report(hash_new);
						end
						lzhc_pkg::OP_SLIDE: begin
							res.valid = 1'b0;
						end
						default: begin
							res.valid = 1'b1;
						end
					endcase
				end
			end
			lzhc_pkg::ST_INS: begin
				head_ctl.wr_en   = 1'b1;
				head_ctl.wr_addr = hash_q;
				head_ctl.wr_data = pos_q;
				link_ctl.wr_en   = 1'b1;
				link_ctl.wr_addr = pos_q[lzhc_pkg::HASH_BITS-1:0];
				link_ctl.wr_data = head_rdata;
				res.valid        = 1'b1;
				res.match        = head_rdata;
			end
			lzhc_pkg::ST_SLIDE: begin
				head_ctl.rd_en   = 1'b1;
				head_ctl.rd_addr = cnt_q;
				link_ctl.rd_en   = 1'b1;
				link_ctl.rd_addr = cnt_q;
				head_ctl.wr_en   = sw_wr_q;
				head_ctl.wr_addr = wa_q;
				head_ctl.wr_data = lzhc_pkg::slide_entry(head_rdata);
				link_ctl.wr_en   = sw_wr_q;
				link_ctl.wr_addr = wa_q;
				link_ctl.wr_data = lzhc_pkg::slide_entry(link_rdata);
			end
			lzhc_pkg::ST_SLIDE_END: begin
				head_ctl.wr_en   = 1'b1;
				head_ctl.wr_addr = wa_q;
				head_ctl.wr_data = lzhc_pkg::slide_entry(head_rdata);
				link_ctl.wr_en   = 1'b1;
				link_ctl.wr_addr = wa_q;
				link_ctl.wr_data = lzhc_pkg::slide_entry(link_rdata);
				res.valid        = 1'b1;
			end
			lzhc_pkg::ST_HOLD: begin
				res.valid = 1'b1;
				res.match = match_q;
			end
			default: begin
				in_stall = 1'b1;
			end
		endcase
	end

	// control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= lzhc_pkg::ST_CLEAR;
			cnt_q   <= '0;
			sw_wr_q <= 1'b0;
			hash_q  <= '0;
		end else begin
			state_q <= state_d;
			case (state_q)
				lzhc_pkg::ST_CLEAR: begin
					cnt_q <= cnt_q + 1'b1;
				end
				lzhc_pkg::ST_IDLE: begin
					cnt_q   <= '0;
					sw_wr_q <= 1'b0;
					if (accept && (operation inside {lzhc_pkg::OP_INSERT,
						lzhc_pkg::OP_UPDATE})) begin
						hash_q <= hash_new;
					end
				end
				lzhc_pkg::ST_SLIDE: begin
					cnt_q   <= cnt_q + 1'b1;
					sw_wr_q <= 1'b1;
				end
				default: begin
					sw_wr_q <= 1'b0;
				end
			endcase
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		if (accept) begin
			pos_q <= position;
		end
		if (state_q == lzhc_pkg::ST_SLIDE) begin
			wa_q <= cnt_q;
		end
		if (res.valid && !res_ready) begin
			match_q <= res.match;
		end
	end

	// an insert write phase always follows an accepted insert
	assert property (@(posedge clk) disable iff (!arst_n)
		state_q == lzhc_pkg::ST_INS |->
		$past(accept) && $past(operation) == lzhc_pkg::OP_INSERT)
		else $error("insert write phase without accepted insert");

	// the clearing pass runs once after reset only
	assert property (@(posedge clk) disable iff (!arst_n)
		state_q != lzhc_pkg::ST_CLEAR |=> state_q != lzhc_pkg::ST_CLEAR)
		else $error("clearing pass re-entered");

	// a held result keeps its hash
	assert property (@(posedge clk) disable iff (!arst_n)
		state_q == lzhc_pkg::ST_HOLD |=> $stable(hash_q))
		else $error("hash changed while result held");

	// a slide ends by offering its result
	assert property (@(posedge clk) disable iff (!arst_n)
		state_q == lzhc_pkg::ST_SLIDE_END |=>
		state_q == lzhc_pkg::ST_IDLE || state_q == lzhc_pkg::ST_HOLD)
		else $error("slide did not finish");

	// sweep writes trail the reads by one entry
	assert property (@(posedge clk) disable iff (!arst_n)
		state_q == lzhc_pkg::ST_SLIDE && sw_wr_q |-> wa_q == cnt_q - 1'b1)
		else $error("slide write address out of step");

endmodule

// ===== sv/lz77_hash_chain_table.sv =====
// LZ77 hash-chain table: rolling hash, head table and link table for a deflate
// match finder. After reset both tables are zeroed by a clearing pass over all
// HASH_ENTRIES entries (32768), during which no item is accepted. An insert
// first reads the head entry through the table's registered read port, then
// writes head and link. A hash-only update or an unused code needs no table
// access. A slide sweeps both tables through one compare-and-subtract per
// table, one entry a cycle, then writes the last entry and offers its result.
// One item is in work at a time; a finished result waits in the output register
// while the next item is accepted.
module lz77_hash_chain_table (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            in_valid,
	output logic                            in_stall,
	input  logic [lzhc_pkg::OP_BITS-1:0]    operation,
	input  logic [lzhc_pkg::BYTE_BITS-1:0]  next_byte,
	input  logic [lzhc_pkg::POS_BITS-1:0]   position,
	output logic                            out_valid,
	input  logic                            out_stall,
	output logic [lzhc_pkg::POS_BITS-1:0]   match_head,
	output logic [lzhc_pkg::INDEX_BITS-1:0] hash_index
);

	lzhc_pkg::ram_ctl_t head_ctl, link_ctl;
	lzhc_pkg::result_t  res;

	logic [lzhc_pkg::POS_BITS-1:0]   head_rdata, link_rdata;
	logic                            res_ready;
	logic                            out_valid_q;
	logic [lzhc_pkg::POS_BITS-1:0]   match_head_q;
	logic [lzhc_pkg::INDEX_BITS-1:0] hash_index_q;

	lzhc_ram #(
		.ADDR_BITS (lzhc_pkg::HASH_BITS),
		.DATA_BITS (lzhc_pkg::POS_BITS)
	) u_head (
		.clk     (clk),
		.rd_en   (head_ctl.rd_en),
		.rd_addr (head_ctl.rd_addr),
		.rd_data (head_rdata),
		.wr_en   (head_ctl.wr_en),
		.wr_addr (head_ctl.wr_addr),
		.wr_data (head_ctl.wr_data)
	);

	lzhc_ram #(
		.ADDR_BITS (lzhc_pkg::HASH_BITS),
		.DATA_BITS (lzhc_pkg::POS_BITS)
	) u_link (
		.clk     (clk),
		.rd_en   (link_ctl.rd_en),
		.rd_addr (link_ctl.rd_addr),
		.rd_data (link_rdata),
		.wr_en   (link_ctl.wr_en),
		.wr_addr (link_ctl.wr_addr),
		.wr_data (link_ctl.wr_data)
	);

	lzhc_seq u_seq (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_stall   (in_stall),
		.operation  (operation),
		.next_byte  (next_byte),
		.position   (position),
		.head_ctl   (head_ctl),
		.link_ctl   (link_ctl),
		.head_rdata (head_rdata),
		.link_rdata (link_rdata),
		.res        (res),
		.res_ready  (res_ready)
	);

	// take a new result when the output register is empty or being drained
	assign res_ready = !out_valid_q || !out_stall;

	// hold the output item until taken
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (res_ready) begin
			out_valid_q <= res.valid;
		end
	end

	// load the output payload
	always_ff @(posedge clk) begin
		if (res_ready && res.valid) begin
			match_head_q <= res.match;
			hash_index_q <= res.hash;
		end
	end

	assign out_valid  = out_valid_q;
	assign match_head = match_head_q;
	assign hash_index = hash_index_q;

endmodule

// ===== sim/lz77_hash_chain_check.sv =====
`timescale 1ns / 100ps

module lz77_hash_chain_check
	import lzhc_pkg::*;
(
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  in_valid,
	input  logic                  in_stall,
	input  logic [OP_BITS-1:0]    operation,
	input  logic [BYTE_BITS-1:0]  next_byte,
	input  logic [POS_BITS-1:0]   position,
	input  logic                  out_valid,
	input  logic                  out_stall,
	input  logic [POS_BITS-1:0]   match_head,
	input  logic [INDEX_BITS-1:0] hash_index,
	output int                    errors,
	output int                    pending,
	output int                    results_checked,
	output int                    chain_hits,
	output int                    slides_seen
);

	typedef struct packed {
		logic [POS_BITS-1:0]   match;
		logic [INDEX_BITS-1:0] hash;
	} chain_result_t;

	// shadow copy of the rolling hash and both tables
	logic [HASH_BITS-1:0] hash_model;
	logic [POS_BITS-1:0]  head_model [HASH_ENTRIES];
	logic [POS_BITS-1:0]  link_model [HASH_ENTRIES];
	chain_result_t        expected_results [$];

	// apply one item to the shadow state and return the result it must give
	function automatic chain_result_t predict_chain(logic [OP_BITS-1:0] op,
		logic [BYTE_BITS-1:0] b, logic [POS_BITS-1:0] pos);
		logic [HASH_BITS+HASH_SHIFT-1:0] widened;
		chain_result_t r;
		int i;
		r.match = '0;
		if (op == OP_INSERT || op == OP_UPDATE) begin
			widened = {hash_model, {HASH_SHIFT{1'b0}}} ^ (HASH_BITS+HASH_SHIFT)'(b);
			hash_model = widened[HASH_BITS-1:0];
		end
		case (op)
		OP_INSERT: begin
			r.match = head_model[hash_model];
			link_model[HASH_BITS'(pos)] = r.match;
			head_model[hash_model] = pos;
		end
		OP_SLIDE: begin
			// pull every entry down by the window, drop the ones that fall out
			for (i = 0; i < HASH_ENTRIES; i++) begin
				head_model[i] = (head_model[i] >= WINDOW_SIZE) ?
					POS_BITS'(head_model[i] - WINDOW_SIZE) : '0;
				link_model[i] = (link_model[i] >= WINDOW_SIZE) ?
					POS_BITS'(link_model[i] - WINDOW_SIZE) : '0;
			end
		end
		default: begin
		end
		endcase
		r.hash = INDEX_BITS'(32'(hash_model));
		return r;
	endfunction

	task automatic report_mismatch(string what);
		errors++;
		if (errors <= 30)
			$display("%0t ns  chain mismatch: %s", $time, what);
	endtask

	// compare each result against the oldest prediction, then queue new ones
	always @(posedge clk or negedge arst_n) begin
		chain_result_t want;
		int i;
		if (!arst_n) begin
			hash_model = '0;
			for (i = 0; i < HASH_ENTRIES; i++) begin
				head_model[i] = '0;
				link_model[i] = '0;
			end
			expected_results.delete();
			errors = 0;
			results_checked = 0;
			chain_hits = 0;
			slides_seen = 0;
		end else begin
			if (out_valid && !out_stall) begin
				if (expected_results.size() == 0) begin
					report_mismatch($sformatf("result match=%h hash=%h with no item pending",
						match_head, hash_index));
				end else begin
					want = expected_results.pop_front();
					results_checked++;
					if (match_head !== want.match)
						report_mismatch($sformatf("match_head %h, expected %h",
							match_head, want.match));
					if (hash_index !== want.hash)
						report_mismatch($sformatf("hash_index %h, expected %h",
							hash_index, want.hash));
					if (want.match != '0)
						chain_hits++;
				end
			end
			if (in_valid && !in_stall) begin
				if (operation == OP_SLIDE)
					slides_seen++;
				expected_results.push_back(predict_chain(operation, next_byte, position));
			end
		end
		pending = expected_results.size();
	end

endmodule

// ===== sim/lz77_hash_chain_table_test.sv =====
`timescale 1ns / 100ps

module lz77_hash_chain_table_test;
	import lzhc_pkg::*;

	localparam logic [OP_BITS-1:0] OP_UNUSED = 2'd3;
	localparam int RANDOM_ITEMS  = 1200;
	localparam int PHASE_ITEMS   = 120;
	localparam int HOLD_CYCLES   = 80;
	localparam int MAX_SLIDES    = 6;
	localparam int SETTLE_CYCLES = 40;

	typedef enum {PH_NONE, PH_SEND_IDLE, PH_RECV_STALL, PH_BOTH, PH_PRESSURE} idle_phase_t;

	logic                  clk = 1'b0;
	logic                  arst_n;
	logic                  in_valid;
	logic                  in_stall;
	logic [OP_BITS-1:0]    operation;
	logic [BYTE_BITS-1:0]  next_byte;
	logic [POS_BITS-1:0]   position;
	logic                  out_valid;
	logic                  out_stall;
	logic [POS_BITS-1:0]   match_head;
	logic [INDEX_BITS-1:0] hash_index;

	int errors;
	int pending;
	int results_checked;
	int chain_hits;
	int slides_seen;

	idle_phase_t         phase = PH_NONE;
	bit                  held_off = 1'b0;
	int                  sent_items = 0;
	int                  random_slides = 0;
	logic [POS_BITS-1:0] stream_pos = '0;

	lz77_hash_chain_table dut (.*);

	lz77_hash_chain_check checker_i (.*);

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	function automatic bit coin(int percent);
		return $urandom_range(0, 99) < percent;
	endfunction

	// offer one item, idling first as the phase asks, and hold it until taken
	task automatic send_item(logic [OP_BITS-1:0] op, logic [BYTE_BITS-1:0] b,
		logic [POS_BITS-1:0] pos);
		int idle_pct;
		idle_pct = (phase == PH_SEND_IDLE) ? 87 : (phase == PH_BOTH) ? 21 : 0;
		while (coin(idle_pct)) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		operation <= op;
		next_byte <= b;
		position <= pos;
		@(posedge clk);
		while (in_stall)
			@(posedge clk);
		sent_items++;
	endtask

	// prime the hash with two bytes, then insert a run of consecutive positions;
	// a narrow byte alphabet makes hashes repeat so chains actually form
	task automatic send_stream();
		int run_len;
		int k;
		bit narrow;
		logic [BYTE_BITS-1:0] base;
		logic [BYTE_BITS-1:0] b;
		run_len = $urandom_range(4, 40);
		narrow = coin(75);
		base = BYTE_BITS'($urandom);
		if (coin(25))
			stream_pos = POS_BITS'($urandom);
		for (k = 0; k < run_len + 2; k++) begin
			b = narrow ? base ^ BYTE_BITS'($urandom_range(0, 3)) : BYTE_BITS'($urandom);
			if (k < 2) begin
				send_item(OP_UPDATE, b, POS_BITS'($urandom));
			end else begin
				send_item(OP_INSERT, b, stream_pos);
				stream_pos++;
			end
		end
	endtask

	// result side: random stall per phase, one long hold-off to back up the block
	initial begin
		out_stall <= 1'b0;
		forever begin
			@(posedge clk);
			if (phase == PH_PRESSURE && !held_off) begin
				held_off = 1'b1;
				out_stall <= 1'b1;
				repeat (HOLD_CYCLES)
					@(posedge clk);
			end
			out_stall <= coin(phase == PH_RECV_STALL ? 87 : phase == PH_BOTH ? 21 : 0);
		end
	end

	initial begin
		int base_count;
		logic [OP_BITS-1:0] noise_op;
		arst_n <= 1'b0;
		in_valid <= 1'b0;
		operation <= OP_INSERT;
		next_byte <= '0;
		position <= '0;
		repeat (4)
			@(posedge clk);
		arst_n <= 1'b1;

		// unused code on a fresh block, then the same three bytes hashed repeatedly
		send_item(OP_UNUSED, 8'hFF, 16'hFFFF);
		send_item(OP_UPDATE, 8'h00, 16'h0000);
		send_item(OP_UPDATE, 8'hFF, 16'hFFFF);
		send_item(OP_INSERT, 8'hAA, 16'h0000);
		send_item(OP_UPDATE, 8'h00, 16'h0000);
		send_item(OP_UPDATE, 8'hFF, 16'h0000);
		send_item(OP_INSERT, 8'hAA, 16'h8001);
		send_item(OP_UPDATE, 8'h00, 16'h0000);
		send_item(OP_UPDATE, 8'hFF, 16'h0000);
		send_item(OP_INSERT, 8'hAA, 16'h7FFF);
		// entries exactly at, just under and far above the window
		send_item(OP_INSERT, 8'h55, 16'h8000);
		send_item(OP_INSERT, 8'h00, 16'hFFFF);
		send_item(OP_INSERT, 8'hFF, 16'h7FFF);
		send_item(OP_SLIDE, 8'hFF, 16'hFFFF);
		// the old chain head lies under the window, so it must come back cleared
		send_item(OP_UPDATE, 8'h00, 16'h0000);
		send_item(OP_UPDATE, 8'hFF, 16'h0000);
		send_item(OP_INSERT, 8'hAA, 16'h1234);
		send_item(OP_UNUSED, 8'h00, 16'h0000);
		send_item(OP_SLIDE, 8'h00, 16'h0000);
		send_item(OP_INSERT, 8'hAA, 16'h5678);

		// mostly insert streams, some noise and the odd slide, phase by phase
		base_count = sent_items;
		while (sent_items - base_count < RANDOM_ITEMS) begin
			phase = idle_phase_t'(((sent_items - base_count) / PHASE_ITEMS) % 5);
			if (random_slides < MAX_SLIDES && coin(8)) begin
				send_item(OP_SLIDE, BYTE_BITS'($urandom), POS_BITS'($urandom));
				random_slides++;
			end else if (coin(80)) begin
				send_stream();
			end else begin
				repeat ($urandom_range(1, 6)) begin
					noise_op = OP_BITS'($urandom_range(0, 3));
					if (noise_op == OP_SLIDE)
						noise_op = OP_UNUSED;
					send_item(noise_op, BYTE_BITS'($urandom), POS_BITS'($urandom));
				end
			end
		end
		in_valid <= 1'b0;
		phase = PH_NONE;

		// let the checker queue the last item, drain, then wait for stray results
		@(posedge clk);
		while (pending != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES)
			@(posedge clk);

		$display("run covered %0d items (%0d slides), %0d results checked",
			sent_items, slides_seen, results_checked);
		$display("chain lookups that found an earlier position: %0d, mismatches: %0d",
			chain_hits, errors);
		if (errors == 0)
			$display("** lz77_hash_chain_table: PASSED **");
		else
			$display("** lz77_hash_chain_table: FAILED **");
		$finish;
	end

	// hang guard: clearing pass, every slide sweep and all idling, many times over
	initial begin
		#4_000_000;
		$display("** lz77_hash_chain_table: FAILED **");
		$finish;
	end

endmodule

// ===== sim.f =====
sv/lzhc_pkg.sv
sv/lzhc_ram.sv
sv/lzhc_seq.sv
sv/lz77_hash_chain_table.sv
sim/lz77_hash_chain_check.sv
sim/lz77_hash_chain_table_test.sv
